// File: rtl/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define PHSP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define PHSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/phsp_pkg.sv
// Package for the packet header summary parser: constants, codes and record types.
// Depends on nothing; used by all parser modules.
`default_nettype none

package phsp_pkg;

   // Header window kept per frame: byte positions 12 through 39.
   localparam int unsigned HDR_FIRST = 12;
   localparam int unsigned HDR_LAST  = 39;
   localparam int unsigned HDR_SPAN  = HDR_LAST - HDR_FIRST + 1;

   // Offsets inside the window (position minus HDR_FIRST).
   localparam int unsigned OFS_ETYPE  = 0;   // positions 12..13
   localparam int unsigned OFS_VER    = 2;   // position 14
   localparam int unsigned OFS_TOTLEN = 4;   // positions 16..17
   localparam int unsigned OFS_V6PAY  = 6;   // positions 18..19
   localparam int unsigned OFS_V6NH   = 8;   // position 20
   localparam int unsigned OFS_TTL    = 10;  // position 22
   localparam int unsigned OFS_PROTO  = 11;  // position 23
   localparam int unsigned OFS_SADDR  = 14;  // positions 26..29
   localparam int unsigned OFS_DADDR  = 18;  // positions 30..33
   localparam int unsigned OFS_SPORT  = 22;  // positions 34..35
   localparam int unsigned OFS_DPORT  = 24;  // positions 36..37
   localparam int unsigned OFS_UDPLEN = 26;  // positions 38..39

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   localparam logic [1:0] CLASS_SHORT = 2'd0;
   localparam logic [1:0] CLASS_OTHER = 2'd1;
   localparam logic [1:0] CLASS_IPV4  = 2'd2;
   localparam logic [1:0] CLASS_IPV6  = 2'd3;

   // Minimum frame lengths for each header to be complete.
   localparam logic [15:0] MIN_ETH  = 16'd14;
   localparam logic [15:0] MIN_IPV4 = 16'd34;
   localparam logic [15:0] MIN_UDP  = 16'd42;
   localparam logic [15:0] MIN_ICMP = 16'd42;
   localparam logic [15:0] MIN_TCP  = 16'd54;
   localparam logic [15:0] MIN_IPV6 = 16'd54;

   // Header sizes taken off to give the payload size.
   localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
   localparam logic [15:0] ICMP_OVERHEAD = 16'd28;
   localparam logic [15:0] TCP_OVERHEAD  = 16'd40;
   localparam logic [15:0] IPV4_OVERHEAD = 16'd20;

   typedef logic [HDR_SPAN-1:0][7:0] hdr_window_type;

   // One finished frame as handed from the front end to the back end.
   typedef struct packed {
      logic [15:0]    frame_length;
      hdr_window_type hdr;
   } frame_record_type;

   // The summary fields of one result transaction.
   typedef struct packed {
      logic [15:0] frame_length;
      logic [1:0]  parse_class;
      logic [3:0]  l3_version;
      logic [7:0]  ip_ttl;
      logic [7:0]  l3_proto;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] payload_length;
   } summary_type;

   typedef struct packed {
      logic [15:0] byte_count;
   } front_status_type;

   typedef struct packed {
      logic [1:0] count;
      logic       full;
   } queue_status_type;

endpackage

`default_nettype wire

// File: rtl/phsp_if.sv
// Valid/ready stream interfaces for the parser's byte input and summary output.
// Depends on nothing.
`default_nettype none

interface phsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface phsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] frame_length;
   logic [1:0]  parse_class;
   logic [3:0]  l3_version;
   logic [7:0]  ip_ttl;
   logic [7:0]  l3_proto;
   logic [31:0] source_address;
   logic [31:0] dest_address;
   logic [15:0] source_port;
   logic [15:0] dest_port;
   logic [15:0] payload_length;

   modport source (
      output valid, output frame_length, output parse_class, output l3_version,
      output ip_ttl, output l3_proto, output source_address, output dest_address,
      output source_port, output dest_port, output payload_length, input ready
   );
   modport sink (
      input valid, input frame_length, input parse_class, input l3_version,
      input ip_ttl, input l3_proto, input source_address, input dest_address,
      input source_port, input dest_port, input payload_length, output ready
   );
endinterface

`default_nettype wire

// File: rtl/phsp_front.sv
// Front end: accepts frame bytes, counts them and captures the header window.
// Depends on phsp_pkg and phsp_req_if.
`default_nettype none

module phsp_front (
   input  logic                        clock,
   input  logic                        reset,
   phsp_req_if.sink                    req,
   output phsp_pkg::frame_record_type  rec,
   output logic                        rec_push,
   input  logic                        rec_full,
   output phsp_pkg::front_status_type  status
);
   import phsp_pkg::*;

   logic [15:0]    count_ff, count_in;
   logic [15:0]    len;
   hdr_window_type hdr_ff, hdr_in;
   logic           accept;

   // Stall only while the queue is full or reset is high.
   assign req.ready = !rec_full && !reset;
   assign accept    = req.valid && req.ready;

   // Length including the current byte, saturating.
   assign len = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 16'd1;

   // Merge the current byte into its window slot so the final byte is seen too.
   always_comb begin
      for (int i = 0; i < HDR_SPAN; i++) begin
         if (accept && (count_ff == 16'(HDR_FIRST + i))) begin
            hdr_in[i] = req.data_byte;
         end else begin
            hdr_in[i] = hdr_ff[i];
         end
      end
   end

   // Byte counter restarts after the final byte of a frame.
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = req.last_byte ? 16'd0 : len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 16'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   // A frame record is pushed on the final byte.
   assign rec_push         = accept && req.last_byte;
   assign rec.frame_length = len;
   assign rec.hdr          = hdr_in;
   assign status.byte_count = count_ff;

endmodule

`default_nettype wire

// File: rtl/phsp_queue.sv
// Two-entry queue of finished frame records between front and back end.
// Depends on phsp_pkg.
`default_nettype none

module phsp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  phsp_pkg::frame_record_type  push_rec,
   input  logic                        push,
   output logic                        full,
   output phsp_pkg::frame_record_type  pop_rec,
   output logic                        pop_valid,
   input  logic                        pop,
   output phsp_pkg::queue_status_type  status
);
   import phsp_pkg::*;

   frame_record_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_rec   = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assign status.count = count_ff;
   assign status.full  = full;

endmodule

`default_nettype wire

// File: rtl/phsp_back.sv
// Back end: parses a frame record into a summary and holds it in the output register.
// Depends on phsp_pkg and phsp_rsp_if.
`default_nettype none

module phsp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  phsp_pkg::frame_record_type  rec,
   input  logic                        rec_valid,
   output logic                        rec_pop,
   phsp_rsp_if.source                  rsp
);
   import phsp_pkg::*;

   function automatic logic [15:0] sub_clamp(input logic [15:0] a, input logic [15:0] b);
      return (a > b) ? a - b : 16'd0;
   endfunction

   summary_type sum;
   summary_type sum_ff;
   logic        valid_ff, valid_in;
   logic [15:0] len;
   logic [15:0] etype;
   logic [15:0] tot_len;
   logic [15:0] udp_len;
   logic [7:0]  proto4;

   assign len     = rec.frame_length;
   assign etype   = {rec.hdr[OFS_ETYPE], rec.hdr[OFS_ETYPE + 1]};
   assign tot_len = {rec.hdr[OFS_TOTLEN], rec.hdr[OFS_TOTLEN + 1]};
   assign udp_len = {rec.hdr[OFS_UDPLEN], rec.hdr[OFS_UDPLEN + 1]};
   assign proto4  = rec.hdr[OFS_PROTO];

   // Classify the frame and pull out the fields its headers allow.
   always_comb begin
      sum              = '0;
      sum.frame_length = len;
      if (len >= MIN_ETH) begin
         if (etype == ETHERTYPE_IPV4) begin
            sum.parse_class = CLASS_IPV4;
            if (len >= MIN_IPV4) begin
               sum.l3_version     = rec.hdr[OFS_VER][7:4];
               sum.ip_ttl         = rec.hdr[OFS_TTL];
               sum.l3_proto       = proto4;
               sum.source_address = {rec.hdr[OFS_SADDR], rec.hdr[OFS_SADDR + 1],
                                     rec.hdr[OFS_SADDR + 2], rec.hdr[OFS_SADDR + 3]};
               sum.dest_address   = {rec.hdr[OFS_DADDR], rec.hdr[OFS_DADDR + 1],
                                     rec.hdr[OFS_DADDR + 2], rec.hdr[OFS_DADDR + 3]};
               if (proto4 == PROTO_UDP) begin
                  if (len >= MIN_UDP) begin
                     sum.source_port    = {rec.hdr[OFS_SPORT], rec.hdr[OFS_SPORT + 1]};
                     sum.dest_port      = {rec.hdr[OFS_DPORT], rec.hdr[OFS_DPORT + 1]};
                     sum.payload_length = sub_clamp(udp_len, UDP_HDR_LEN);
                  end
               end else if (proto4 == PROTO_ICMP) begin
                  if (len >= MIN_ICMP) begin
                     sum.payload_length = sub_clamp(tot_len, ICMP_OVERHEAD);
                  end
               end else if (proto4 == PROTO_TCP) begin
                  if (len >= MIN_TCP) begin
                     sum.source_port    = {rec.hdr[OFS_SPORT], rec.hdr[OFS_SPORT + 1]};
                     sum.dest_port      = {rec.hdr[OFS_DPORT], rec.hdr[OFS_DPORT + 1]};
                     sum.payload_length = sub_clamp(tot_len, TCP_OVERHEAD);
                  end
               end else begin
                  sum.payload_length = sub_clamp(tot_len, IPV4_OVERHEAD);
               end
            end
         end else if (etype == ETHERTYPE_IPV6) begin
            sum.parse_class = CLASS_IPV6;
            if (len >= MIN_IPV6) begin
               sum.l3_version     = rec.hdr[OFS_VER][7:4];
               sum.payload_length = {rec.hdr[OFS_V6PAY], rec.hdr[OFS_V6PAY + 1]};
               sum.l3_proto       = rec.hdr[OFS_V6NH];
            end
         end else begin
            sum.parse_class = CLASS_OTHER;
         end
      end else begin
         sum.parse_class = CLASS_SHORT;
      end
   end

   // Load the output register whenever it is empty or being drained.
   assign rec_pop = rec_valid && (!valid_ff || rsp.ready);

   always_comb begin
      valid_in = valid_ff;
      if (rec_pop) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         sum_ff <= sum;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.frame_length   = sum_ff.frame_length;
   assign rsp.parse_class    = sum_ff.parse_class;
   assign rsp.l3_version     = sum_ff.l3_version;
   assign rsp.ip_ttl         = sum_ff.ip_ttl;
   assign rsp.l3_proto       = sum_ff.l3_proto;
   assign rsp.source_address = sum_ff.source_address;
   assign rsp.dest_address   = sum_ff.dest_address;
   assign rsp.source_port    = sum_ff.source_port;
   assign rsp.dest_port      = sum_ff.dest_port;
   assign rsp.payload_length = sum_ff.payload_length;

endmodule

`default_nettype wire

// File: rtl/packet_header_summary_parser_unit.sv
// Top level of the packet header summary parser: front end, record queue, back end.
// Depends on phsp_pkg, phsp_if, phsp_front, phsp_queue, phsp_back and assert_macros.svh.
//
//   Channel      Direction  Transaction
//   req_stream   in         one frame byte with a final-byte flag
//   rsp_stream   out        one frame summary, after each final byte
//
// One byte is accepted per cycle while ready is high; bytes are only counted and captured.
// After its final byte, a summary passes through the queue, then the output register.
// Input stalls only when the two-entry record queue is full, which takes a
// stalled output channel; ready is low during reset.
// Synchronous reset clears the byte count, the queue and the output valid.
`default_nettype none
`include "assert_macros.svh"

module packet_header_summary_parser_unit (
   input  logic     clock,
   input  logic     reset,
   phsp_req_if.sink   req_stream,
   phsp_rsp_if.source rsp_stream
);
   import phsp_pkg::*;

   frame_record_type front_rec;
   frame_record_type back_rec;
   logic             rec_push;
   logic             rec_full;
   logic             rec_valid;
   logic             rec_pop;
   front_status_type front_status;
   queue_status_type queue_status;

   phsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_stream),
      .rec      (front_rec),
      .rec_push (rec_push),
      .rec_full (rec_full),
      .status   (front_status)
   );

   phsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_rec  (front_rec),
      .push      (rec_push),
      .full      (rec_full),
      .pop_rec   (back_rec),
      .pop_valid (rec_valid),
      .pop       (rec_pop),
      .status    (queue_status)
   );

   phsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec       (back_rec),
      .rec_valid (rec_valid),
      .rec_pop   (rec_pop),
      .rsp       (rsp_stream)
   );

   // Consistency checks between front end, queue and output register.
   `PHSP_ASSERT_ALWAYS(a_queue_bound, clock, reset, (queue_status.count != 2'd3), "queue overflow")
   `PHSP_ASSERT_NEXT(a_count_restart, clock, reset, (req_stream.valid && req_stream.ready && req_stream.last_byte), (front_status.byte_count == 16'd0), "byte count not restarted")
   `PHSP_ASSERT_NEXT(a_record_kept, clock, reset, (req_stream.valid && req_stream.ready && req_stream.last_byte), (queue_status.count != 2'd0 || rsp_stream.valid), "frame record lost")

endmodule

`default_nettype wire

// File: tb/sv/packet_header_summary_parser_unit_test.sv
// Self-checking testbench for the packet header summary parser unit.
// Depends on phsp_pkg and phsp_if; drives bytes, predicts each summary and checks it.
// Covers directed header corner cases, random well-formed and broken frames, and stalls.
module packet_header_summary_parser_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import phsp_pkg::*;

   localparam int unsigned STORE_BYTES   = 64;
   localparam int unsigned IDLE_LIMIT    = 5000;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_BYTES  = 650;
   localparam int unsigned RANDOM_FRAMES = 12;

   // Byte positions of the header fields, counted from the destination address.
   localparam int unsigned POS_ETYPE  = 12;
   localparam int unsigned POS_VER    = 14;
   localparam int unsigned POS_TOTLEN = 16;
   localparam int unsigned POS_V6PAY  = 18;
   localparam int unsigned POS_V6NH   = 20;
   localparam int unsigned POS_TTL    = 22;
   localparam int unsigned POS_PROTO  = 23;
   localparam int unsigned POS_SADDR  = 26;
   localparam int unsigned POS_DADDR  = 30;
   localparam int unsigned POS_SPORT  = 34;
   localparam int unsigned POS_DPORT  = 36;
   localparam int unsigned POS_UDPLEN = 38;

   typedef enum int unsigned {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_type;
   typedef logic [7:0] frame_bytes_type[$];

   // Tracks the frame in progress and holds the summaries still owed by the block.
   class frame_summary_predictor;
      logic [15:0] byte_count;
      logic [7:0]  header_bytes[STORE_BYTES];
      summary_type expected_summaries[$];
      int unsigned mismatch_count;

      function new();
         byte_count = '0;
         mismatch_count = 0;
         foreach (header_bytes[i]) header_bytes[i] = '0;
      endfunction

      function int unsigned pending();
         return expected_summaries.size();
      endfunction

      function logic [15:0] be16(int unsigned pos);
         return {header_bytes[pos], header_bytes[pos + 1]};
      endfunction

      function logic [15:0] minus_floor(logic [15:0] a, logic [15:0] b);
         return (a > b) ? a - b : 16'd0;
      endfunction

      // Called for each accepted byte transaction; a final byte queues one summary.
      function void note_byte(logic [7:0] data, logic last);
         summary_type s;
         logic [15:0] len;
         if (byte_count < STORE_BYTES) header_bytes[byte_count] = data;
         len = (byte_count != COUNT_MAX) ? byte_count + 16'd1 : COUNT_MAX;
         if (!last) begin
            byte_count = len;
            return;
         end
         byte_count = '0;
         s = '0;
         s.frame_length = len;
         s.parse_class = CLASS_SHORT;
         if (len >= MIN_ETH) begin
            if (be16(POS_ETYPE) == ETHERTYPE_IPV4) begin
               s.parse_class = CLASS_IPV4;
               if (len >= MIN_IPV4) begin
                  s.l3_version = header_bytes[POS_VER][7:4];
                  s.ip_ttl = header_bytes[POS_TTL];
                  s.l3_proto = header_bytes[POS_PROTO];
                  s.source_address = {be16(POS_SADDR), be16(POS_SADDR + 2)};
                  s.dest_address = {be16(POS_DADDR), be16(POS_DADDR + 2)};
                  // For UDP, ICMP and TCP, ports and payload only count once the L4 header is complete.
                  case (s.l3_proto)
                     PROTO_UDP: begin
                        if (len >= MIN_UDP) begin
                           s.source_port = be16(POS_SPORT);
                           s.dest_port = be16(POS_DPORT);
                           s.payload_length = minus_floor(be16(POS_UDPLEN), UDP_HDR_LEN);
                        end
                     end
                     PROTO_ICMP: begin
                        if (len >= MIN_ICMP)
                           s.payload_length = minus_floor(be16(POS_TOTLEN), ICMP_OVERHEAD);
                     end
                     PROTO_TCP: begin
                        if (len >= MIN_TCP) begin
                           s.source_port = be16(POS_SPORT);
                           s.dest_port = be16(POS_DPORT);
                           s.payload_length = minus_floor(be16(POS_TOTLEN), TCP_OVERHEAD);
                        end
                     end
                     default: begin
                        s.payload_length = minus_floor(be16(POS_TOTLEN), IPV4_OVERHEAD);
                     end
                  endcase
               end
            end else if (be16(POS_ETYPE) == ETHERTYPE_IPV6) begin
               s.parse_class = CLASS_IPV6;
               if (len >= MIN_IPV6) begin
                  s.l3_version = header_bytes[POS_VER][7:4];
                  s.payload_length = be16(POS_V6PAY);
                  s.l3_proto = header_bytes[POS_V6NH];
               end
            end else begin
               s.parse_class = CLASS_OTHER;
            end
         end
         expected_summaries.push_back(s);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      // Called for each accepted summary transaction.
      function void check_summary(summary_type got);
         summary_type want;
         if (expected_summaries.size() == 0) begin
            $display("%0t: summary with nothing expected: expected none, actual length %0d",
                     $time, got.frame_length);
            mismatch_count++;
            return;
         end
         want = expected_summaries.pop_front();
         compare_field("frame_length", want.frame_length, got.frame_length);
         compare_field("parse_class", want.parse_class, got.parse_class);
         compare_field("l3_version", want.l3_version, got.l3_version);
         compare_field("ip_ttl", want.ip_ttl, got.ip_ttl);
         compare_field("l3_proto", want.l3_proto, got.l3_proto);
         compare_field("source_address", want.source_address, got.source_address);
         compare_field("dest_address", want.dest_address, got.dest_address);
         compare_field("source_port", want.source_port, got.source_port);
         compare_field("dest_port", want.dest_port, got.dest_port);
         compare_field("payload_length", want.payload_length, got.payload_length);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_request = 1'b0;
   int unsigned burst_left = 0;
   frame_summary_predictor predictor;

   phsp_req_if req_stream();
   phsp_rsp_if rsp_stream();

   packet_header_summary_parser_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .rsp_stream (rsp_stream)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Writes one byte only where the frame is long enough to hold it.
   function automatic void put_byte(ref frame_bytes_type f, input int unsigned pos,
                                    input logic [7:0] value);
      if (pos < f.size()) f[pos] = value;
   endfunction

   // Builds a frame of the given length with the chosen header fields laid over the fill.
   function automatic void build_frame(ref frame_bytes_type f, input int unsigned len,
                                       input logic [15:0] etype, input logic [7:0] proto,
                                       input logic [15:0] tot, input logic [15:0] l4len,
                                       input fill_kind_type fill);
      f.delete();
      for (int unsigned i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: f.push_back(8'h00);
            FILL_ONES: f.push_back(8'hFF);
            default:   f.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      put_byte(f, POS_ETYPE, etype[15:8]);
      put_byte(f, POS_ETYPE + 1, etype[7:0]);
      // Mostly a plausible version nibble, now and then anything.
      if (fill == FILL_RANDOM && POS_VER < f.size() && $urandom_range(0, 7) != 0)
         f[POS_VER][7:4] = (etype == ETHERTYPE_IPV6) ? 4'd6 : 4'd4;
      if (etype == ETHERTYPE_IPV6) begin
         put_byte(f, POS_V6PAY, tot[15:8]);
         put_byte(f, POS_V6PAY + 1, tot[7:0]);
         put_byte(f, POS_V6NH, proto);
      end else begin
         put_byte(f, POS_TOTLEN, tot[15:8]);
         put_byte(f, POS_TOTLEN + 1, tot[7:0]);
         put_byte(f, POS_PROTO, proto);
         put_byte(f, POS_UDPLEN, l4len[15:8]);
         put_byte(f, POS_UDPLEN + 1, l4len[7:0]);
      end
   endfunction

   // Offers one byte from a falling edge and returns at the falling edge after acceptance.
   task automatic push_byte(input logic [7:0] data, input logic last);
      req_stream.valid <= 1'b1;
      req_stream.data_byte <= data;
      req_stream.last_byte <= last;
      do @(posedge clock); while (req_stream.ready !== 1'b1);
      predictor.note_byte(data, last);
      @(negedge clock);
   endtask

   // Sends a frame in bursts of random length separated by random gaps.
   task automatic send_frame(ref frame_bytes_type f);
      int unsigned gap;
      for (int unsigned i = 0; i < f.size(); i++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_stream.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
         end
         burst_left--;
         push_byte(f[i], i == f.size() - 1);
      end
   endtask

   // Stops sending until every summary owed has come out, then lets the block settle.
   task automatic wait_drained();
      req_stream.valid <= 1'b0;
      while (predictor.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Asks the receiver for a long hold-off and keeps offering tiny frames meanwhile.
   task automatic pressure_burst();
      frame_bytes_type f;
      hold_request = 1'b1;
      repeat (10) begin
         build_frame(f, $urandom_range(1, 3), 16'h0000, 8'h00, 16'h0000, 16'h0000,
                     FILL_RANDOM);
         send_frame(f);
      end
   endtask

   // Receiver: cycles through always-ready, random and fixed-shape stall phases.
   initial begin
      int unsigned tick;
      int unsigned hold_left;
      logic [7:0] shape;
      tick = 0;
      hold_left = 0;
      shape = 8'hA5;
      rsp_stream.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (tick % 150 == 0) shape = 8'($urandom_range(1, 255));
         if (hold_left != 0) begin
            hold_left--;
            rsp_stream.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_stream.ready <= 1'b0;
         end else begin
            case ((tick / 150) % 4)
               0: rsp_stream.ready <= 1'b1;
               1: rsp_stream.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_stream.ready <= shape[tick % 8];
               default: rsp_stream.ready <= ($urandom_range(0, 1) != 0);
            endcase
         end
         tick++;
         @(negedge clock);
      end
   end

   // Summary monitor: checks each accepted result transaction.
   initial begin
      summary_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_stream.valid === 1'b1 && rsp_stream.ready === 1'b1) begin
            got.frame_length = rsp_stream.frame_length;
            got.parse_class = rsp_stream.parse_class;
            got.l3_version = rsp_stream.l3_version;
            got.ip_ttl = rsp_stream.ip_ttl;
            got.l3_proto = rsp_stream.l3_proto;
            got.source_address = rsp_stream.source_address;
            got.dest_address = rsp_stream.dest_address;
            got.source_port = rsp_stream.source_port;
            got.dest_port = rsp_stream.dest_port;
            got.payload_length = rsp_stream.payload_length;
            predictor.check_summary(got);
         end
      end
   end

   // Watchdog: ends the run when no transaction moves on either channel for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_stream.valid === 1'b1 && req_stream.ready === 1'b1) ||
             (rsp_stream.valid === 1'b1 && rsp_stream.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Stimulus: directed corner cases, then random frames with pressure phases.
   initial begin
      frame_bytes_type f;
      int unsigned sent_bytes;
      int unsigned sent_frames;
      int unsigned len;
      logic [15:0] etype;
      logic [15:0] tot;
      logic [15:0] l4len;
      logic [7:0] proto;
      predictor = new();
      req_stream.valid = 1'b0;
      req_stream.data_byte = 8'h00;
      req_stream.last_byte = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Short frames and the Ethernet header boundary.
      build_frame(f, 1, ETHERTYPE_IPV4, PROTO_UDP, 16'd0, 16'd0, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 13, ETHERTYPE_IPV4, PROTO_UDP, 16'd0, 16'd0, FILL_ONES);
      send_frame(f);
      build_frame(f, 14, 16'h0000, 8'h00, 16'd0, 16'd0, FILL_ZERO);
      send_frame(f);
      build_frame(f, 14, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, FILL_ONES);
      send_frame(f);
      // Truncated IPv4 and incomplete L4 headers.
      build_frame(f, 14, ETHERTYPE_IPV4, PROTO_UDP, 16'd60, 16'd40, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 33, ETHERTYPE_IPV4, PROTO_UDP, 16'd60, 16'd40, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 34, ETHERTYPE_IPV4, PROTO_UDP, 16'd60, 16'd40, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 41, ETHERTYPE_IPV4, PROTO_UDP, 16'd60, 16'd40, FILL_RANDOM);
      send_frame(f);
      // UDP: normal length, length below and equal to the UDP header.
      build_frame(f, 42, ETHERTYPE_IPV4, PROTO_UDP, 16'd128, 16'd100, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 42, ETHERTYPE_IPV4, PROTO_UDP, 16'd128, 16'd3, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 42, ETHERTYPE_IPV4, PROTO_UDP, 16'd128, 16'd8, FILL_RANDOM);
      send_frame(f);
      // ICMP: incomplete, normal and clamped payload.
      build_frame(f, 41, ETHERTYPE_IPV4, PROTO_ICMP, 16'd84, 16'd0, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 42, ETHERTYPE_IPV4, PROTO_ICMP, 16'd84, 16'd0, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 42, ETHERTYPE_IPV4, PROTO_ICMP, 16'd20, 16'd0, FILL_RANDOM);
      send_frame(f);
      // TCP: incomplete, normal and exactly the header overhead.
      build_frame(f, 53, ETHERTYPE_IPV4, PROTO_TCP, 16'd1500, 16'd0, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 54, ETHERTYPE_IPV4, PROTO_TCP, 16'd1500, 16'd0, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 54, ETHERTYPE_IPV4, PROTO_TCP, 16'd40, 16'd0, FILL_RANDOM);
      send_frame(f);
      // Other protocols, the largest total length and an all-zero header.
      build_frame(f, 34, ETHERTYPE_IPV4, 8'h2F, 16'hFFFF, 16'd0, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 34, ETHERTYPE_IPV4, 8'h2F, 16'd5, 16'd0, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 34, ETHERTYPE_IPV4, 8'hFF, 16'hFFFF, 16'hFFFF, FILL_ONES);
      send_frame(f);
      build_frame(f, 54, ETHERTYPE_IPV4, 8'h00, 16'h0000, 16'h0000, FILL_ZERO);
      send_frame(f);
      // IPv6: truncated, complete and long.
      build_frame(f, 53, ETHERTYPE_IPV6, PROTO_TCP, 16'd200, 16'd0, FILL_RANDOM);
      send_frame(f);
      build_frame(f, 54, ETHERTYPE_IPV6, PROTO_TCP, 16'hFFFF, 16'd0, FILL_ONES);
      send_frame(f);
      build_frame(f, 200, ETHERTYPE_IPV6, PROTO_UDP, 16'd146, 16'd0, FILL_RANDOM);
      send_frame(f);
      // A long frame that runs past the header store.
      build_frame(f, 100, ETHERTYPE_IPV4, PROTO_TCP, 16'd86, 16'd0, FILL_RANDOM);
      send_frame(f);
      wait_drained();

      // Random frames: mostly shaped headers around the length thresholds.
      sent_bytes = 0;
      sent_frames = 0;
      while (sent_bytes < RANDOM_BYTES || sent_frames < RANDOM_FRAMES) begin
         if (sent_frames == 3 || sent_frames == 9) pressure_burst();
         if (sent_frames == 6) wait_drained();
         tot = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
         l4len = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 200) : $urandom_range(30, 70);
         case ($urandom_range(0, 3))
            0: proto = PROTO_UDP;
            1: proto = PROTO_TCP;
            2: proto = PROTO_ICMP;
            default: proto = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: etype = ETHERTYPE_IPV4;
            4, 5: etype = ETHERTYPE_IPV6;
            6: begin
               // Ethertypes one bit away from the IP ones.
               etype = (($urandom_range(0, 1) != 0) ? ETHERTYPE_IPV4 : ETHERTYPE_IPV6)
                       ^ (16'd1 << $urandom_range(0, 15));
               len = $urandom_range(14, 70);
            end
            7: begin
               etype = ETHERTYPE_IPV4;
               len = $urandom_range(1, 13);
            end
            8: begin
               etype = ETHERTYPE_IPV4;
               proto = 8'($urandom_range(0, 255));
               len = $urandom_range(14, 70);
            end
            default: begin
               etype = 16'($urandom);
               len = $urandom_range(1, 80);
            end
         endcase
         build_frame(f, len, etype, proto, tot, l4len, FILL_RANDOM);
         send_frame(f);
         sent_bytes += f.size();
         sent_frames++;
      end
      wait_drained();

      if (predictor.mismatch_count == 0 && predictor.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/phsp_pkg.sv
rtl/phsp_if.sv
rtl/phsp_front.sv
rtl/phsp_queue.sv
rtl/phsp_back.sv
rtl/packet_header_summary_parser_unit.sv
tb/sv/packet_header_summary_parser_unit_test.sv
